@@ design/grid_maze_backtracker_assert.svh @@
// Assertion macros shared by the maze carver RTL.
`ifndef GRID_MAZE_BACKTRACKER_ASSERT_SVH
`define GRID_MAZE_BACKTRACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GMB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/gmb_pkg.sv @@
`default_nettype none

package gmb_pkg;

  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned OUT_CW    = 6;
  localparam int unsigned EPOCH_W   = 4;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_e;

  typedef enum logic [1:0] {
    EV_START = 2'd0,
    EV_CARVE = 2'd1,
    EV_BACK  = 2'd2,
    EV_IDLE  = 2'd3
  } event_e;

  typedef enum logic {
    FN_START = 1'b0,
    FN_STEP  = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS = 1'b0,
    CFG_ROWS = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STK_NONE  = 2'd0,
    STK_START = 2'd1,
    STK_PUSH  = 2'd2,
    STK_POP   = 2'd3
  } stk_op_e;

  typedef logic [3:0][1:0] dir_order_t;

  localparam dir_order_t DIR_INIT = {2'd3, 2'd2, 2'd1, 2'd0};

  typedef struct packed {
    logic       func;
    logic [1:0] pick_first;
    logic [1:0] pick_second;
    logic [1:0] pick_third;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic [OUT_CW-1:0] cell_x;
    logic [OUT_CW-1:0] cell_y;
    logic [1:0]        carve_dir;
    logic              done_res;
  } out_beat_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic renew;
  } vis_req_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last;
  } stk_stat_t;

  // Swap position i with its pick when the pick lies above i.
  function automatic dir_order_t shuffle_dirs(logic [1:0] p0, logic [1:0] p1,
                                              logic [1:0] p2);
    dir_order_t order;
    logic [2:0][1:0] picks;
    logic [1:0] tmp;
    order = DIR_INIT;
    picks = {p2, p1, p0};
    for (int i = 0; i < 3; i++) begin
      if (picks[i] > 2'(i)) begin
        tmp             = order[i];
        order[i]        = order[picks[i]];
        order[picks[i]] = tmp;
      end
    end
    return order;
  endfunction

endpackage

`default_nettype wire

@@ design/gmb_visit_map.sv @@
`default_nettype none

module gmb_visit_map import gmb_pkg::*; #(
  parameter int unsigned Cells = 4096,
  localparam int unsigned AddrW = $clog2(Cells)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire vis_req_t         req_i,
  input  wire logic [AddrW-1:0] addr_i,
  output logic                  busy_o,
  output logic                  visited_o
);

  localparam logic [AddrW-1:0] LAST_ADDR = AddrW'(Cells - 1);

  // Each entry holds the epoch of the maze that last marked it.
  logic [EPOCH_W-1:0] mem_q [Cells];
  logic [EPOCH_W-1:0] rd_q;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic               sweep_q, sweep_d;
  logic [AddrW-1:0]   sweep_addr_q, sweep_addr_d;

  always_ff @(posedge clk_i) begin
    if (sweep_q) begin
      mem_q[sweep_addr_q] <= '0;
    end else if (req_i.wr_en) begin
      mem_q[addr_i] <= epoch_q;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[addr_i];
    end
  end

  always_comb begin
    epoch_d      = epoch_q;
    sweep_d      = sweep_q;
    sweep_addr_d = sweep_addr_q;
    if (sweep_q) begin
      sweep_addr_d = sweep_addr_q + AddrW'(1);
      if (sweep_addr_q == LAST_ADDR) begin
        sweep_d = 1'b0;
      end
    end else if (req_i.renew) begin
      // Wrapping the epoch back to 1 also starts a pass that wipes every stale mark.
      if (epoch_q == '1) begin
        epoch_d      = EPOCH_W'(1);
        sweep_d      = 1'b1;
        sweep_addr_d = '0;
      end else begin
        epoch_d = epoch_q + EPOCH_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q      <= '0;
      sweep_q      <= 1'b1;
      sweep_addr_q <= '0;
    end else begin
      epoch_q      <= epoch_d;
      sweep_q      <= sweep_d;
      sweep_addr_q <= sweep_addr_d;
    end
  end

  assign busy_o    = sweep_q;
  assign visited_o = (rd_q == epoch_q);

endmodule

`default_nettype wire

@@ design/gmb_path_stack.sv @@
`default_nettype none

module gmb_path_stack import gmb_pkg::*; #(
  parameter int unsigned Cells = 4096,
  parameter int unsigned XW = 6,
  parameter int unsigned YW = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire stk_op_e       op_i,
  input  wire logic [XW-1:0] push_x_i,
  input  wire logic [YW-1:0] push_y_i,
  output logic [XW-1:0]      top_x_o,
  output logic [YW-1:0]      top_y_o,
  output stk_stat_t          stat_o
);

  localparam int unsigned EntryW = XW + YW;
  localparam int unsigned AddrW  = $clog2(Cells);
  localparam int unsigned DepthW = $clog2(Cells + 1);

  logic [EntryW-1:0] mem_q [Cells];
  logic [EntryW-1:0] rd_q;
  logic [EntryW-1:0] top_q;
  logic [DepthW-1:0] depth_q, depth_d;
  logic              reload_q;

  logic              wr_en, rd_en;
  logic [AddrW-1:0]  wr_addr, rd_addr;
  logic [EntryW-1:0] wr_data;

  assign stat_o.empty = (depth_q == '0);
  assign stat_o.full  = (depth_q == DepthW'(Cells));
  assign stat_o.last  = (depth_q == DepthW'(1));

  assign wr_en   = (op_i == STK_PUSH) || (op_i == STK_START);
  assign wr_addr = (op_i == STK_START) ? '0 : depth_q[AddrW-1:0];
  assign wr_data = (op_i == STK_START) ? '0 : {push_y_i, push_x_i};
  // A pop from a single entry leaves nothing to reload.
  assign rd_en   = (op_i == STK_POP) && !stat_o.last;
  assign rd_addr = AddrW'(depth_q - DepthW'(2));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      top_q <= wr_data;
    end else if (reload_q) begin
      top_q <= rd_q;
    end
  end

  always_comb begin
    depth_d = depth_q;
    case (op_i)
      STK_START: depth_d = DepthW'(1);
      STK_PUSH:  depth_d = depth_q + DepthW'(1);
      STK_POP:   depth_d = depth_q - DepthW'(1);
      default:   depth_d = depth_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= '0;
      reload_q <= 1'b0;
    end else begin
      depth_q  <= depth_d;
      reload_q <= rd_en;
    end
  end

  assign top_x_o = top_q[XW-1:0];
  assign top_y_o = top_q[EntryW-1:XW];

endmodule

`default_nettype wire

@@ design/grid_maze_backtracker.sv @@
// Depth-first maze carver over a grid of up to MAX_COLS by MAX_ROWS cells. A start beat
// opens a new maze at cell (0,0); each step beat carves one passage or backs up one
// cell and returns exactly one result beat. The visited map has a single memory port, so
// a step probes its shuffled directions one per cycle until the first open one, trying
// all four when none is open; the next beat is taken only after the result has moved
// into the output register.
// Visited marks carry a 4-bit maze epoch instead of being wiped per start. After reset,
// and on one start in every fifteen when the epoch wraps, a clearing pass writes the
// whole visited memory, during which no beat is taken (configuration writes still are).
// Grid sizes of 0 act as 1 and sizes above the maximum act as the maximum. A result
// waiting on a stalled output does not block acceptance.
`default_nettype none

`include "grid_maze_backtracker_assert.svh"

module grid_maze_backtracker import gmb_pkg::*; #(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_beat_t             in_beat_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_beat_t                 out_beat_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned XW    = $clog2(MAX_COLS);
  localparam int unsigned YW    = $clog2(MAX_ROWS);
  localparam int unsigned XCW   = XW + 1;
  localparam int unsigned YCW   = YW + 1;
  localparam int unsigned CELLS = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(CELLS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MARK = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CFG_W-1:0] cols_cfg_q, rows_cfg_q;
  logic [XCW-1:0]  cols_eff;
  logic [YCW-1:0]  rows_eff;

  dir_order_t      order_q, order_d;
  logic [1:0]      iss_q, iss_d;
  logic            chk_vld_q, chk_vld_d;
  logic            chk_inb_q, chk_inb_d;
  logic            chk_last_q, chk_last_d;
  logic [1:0]      chk_dir_q, chk_dir_d;
  logic [XW-1:0]   chk_x_q, chk_x_d;
  logic [YW-1:0]   chk_y_q, chk_y_d;
  logic [AW-1:0]   chk_addr_q, chk_addr_d;
  out_beat_t       res_q, res_d;
  logic            res_we;
  logic            out_valid_q, out_valid_d;
  out_beat_t       out_beat_q;
  logic            out_free;
  logic            in_accept;

  vis_req_t        vis_req;
  logic [AW-1:0]   vis_addr;
  logic            vis_busy, vis_visited;
  stk_op_e         stk_op;
  logic [XW-1:0]   top_x;
  logic [YW-1:0]   top_y;
  stk_stat_t       stk_stat;

  dir_e            cur_dir;
  logic [XCW-1:0]  cand_x_ext;
  logic [YCW-1:0]  cand_y_ext;
  logic            cand_edge_ok, cand_inb, chk_free;
  logic [AW-1:0]   cand_addr;

  gmb_visit_map #(
    .Cells(CELLS)
  ) u_visit_map (
    .clk_i,
    .rst_ni,
    .req_i    (vis_req),
    .addr_i   (vis_addr),
    .busy_o   (vis_busy),
    .visited_o(vis_visited)
  );

  gmb_path_stack #(
    .Cells(CELLS),
    .XW   (XW),
    .YW   (YW)
  ) u_path_stack (
    .clk_i,
    .rst_ni,
    .op_i    (stk_op),
    .push_x_i(chk_x_q),
    .push_y_i(chk_y_q),
    .top_x_o (top_x),
    .top_y_o (top_y),
    .stat_o  (stk_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= CFG_W'(64);
      rows_cfg_q <= CFG_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLS: cols_cfg_q <= cfg_wdata_i;
        CFG_ROWS: rows_cfg_q <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  always_comb begin
    if (cols_cfg_q == '0) begin
      cols_eff = XCW'(1);
    end else if (32'(cols_cfg_q) > MAX_COLS) begin
      cols_eff = XCW'(MAX_COLS);
    end else begin
      cols_eff = XCW'(cols_cfg_q);
    end
    if (rows_cfg_q == '0) begin
      rows_eff = YCW'(1);
    end else if (32'(rows_cfg_q) > MAX_ROWS) begin
      rows_eff = YCW'(MAX_ROWS);
    end else begin
      rows_eff = YCW'(rows_cfg_q);
    end
  end

  // Neighbor of the top cell in the direction under probe.
  assign cur_dir = dir_e'(order_q[iss_q]);

  always_comb begin
    cand_x_ext   = {1'b0, top_x};
    cand_y_ext   = {1'b0, top_y};
    cand_edge_ok = 1'b1;
    case (cur_dir)
      DIR_UP: begin
        cand_edge_ok = (top_y != '0);
        cand_y_ext   = {1'b0, top_y} - YCW'(1);
      end
      DIR_RIGHT: cand_x_ext = {1'b0, top_x} + XCW'(1);
      DIR_DOWN:  cand_y_ext = {1'b0, top_y} + YCW'(1);
      DIR_LEFT: begin
        cand_edge_ok = (top_x != '0);
        cand_x_ext   = {1'b0, top_x} - XCW'(1);
      end
      default: cand_edge_ok = 1'b0;
    endcase
    cand_inb  = cand_edge_ok && (cand_x_ext < cols_eff) && (cand_y_ext < rows_eff);
    cand_addr = AW'(32'(cand_y_ext[YW-1:0]) * MAX_COLS + 32'(cand_x_ext[XW-1:0]));
  end

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || vis_busy;
  assign out_free = !out_valid_q || !out_stall_i;
  assign chk_free = chk_vld_q && chk_inb_q && !vis_visited && !stk_stat.full;

  always_comb begin
    state_d    = state_q;
    order_d    = order_q;
    iss_d      = iss_q;
    chk_vld_d  = chk_vld_q;
    chk_inb_d  = chk_inb_q;
    chk_last_d = chk_last_q;
    chk_dir_d  = chk_dir_q;
    chk_x_d    = chk_x_q;
    chk_y_d    = chk_y_q;
    chk_addr_d = chk_addr_q;
    res_d      = res_q;
    res_we     = 1'b0;
    vis_req    = '0;
    vis_addr   = cand_addr;
    stk_op     = STK_NONE;
    out_valid_d = out_valid_q;

    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (in_beat_i.func == FN_START) begin
            vis_req.renew = 1'b1;
            state_d       = S_MARK;
          end else if (stk_stat.empty) begin
            res_we           = 1'b1;
            res_d            = '0;
            res_d.event_kind = EV_IDLE;
            res_d.done_res   = 1'b1;
            state_d          = S_EMIT;
          end else begin
            order_d   = shuffle_dirs(in_beat_i.pick_first, in_beat_i.pick_second,
                                     in_beat_i.pick_third);
            iss_d     = '0;
            chk_vld_d = 1'b0;
            state_d   = S_SCAN;
          end
        end
      end
      S_MARK: begin
        // Hold until any clearing pass is over, then mark the origin.
        if (!vis_busy) begin
          vis_req.wr_en    = 1'b1;
          vis_addr         = '0;
          stk_op           = STK_START;
          res_we           = 1'b1;
          res_d            = '0;
          res_d.event_kind = EV_START;
          state_d          = S_EMIT;
        end
      end
      S_SCAN: begin
        if (chk_free) begin
          vis_req.wr_en    = 1'b1;
          vis_addr         = chk_addr_q;
          stk_op           = STK_PUSH;
          res_we           = 1'b1;
          res_d.event_kind = EV_CARVE;
          res_d.cell_x     = OUT_CW'(top_x);
          res_d.cell_y     = OUT_CW'(top_y);
          res_d.carve_dir  = chk_dir_q;
          res_d.done_res   = 1'b0;
          chk_vld_d        = 1'b0;
          state_d          = S_EMIT;
        end else if (chk_vld_q && chk_last_q) begin
          stk_op           = STK_POP;
          res_we           = 1'b1;
          res_d.event_kind = EV_BACK;
          res_d.cell_x     = OUT_CW'(top_x);
          res_d.cell_y     = OUT_CW'(top_y);
          res_d.carve_dir  = DIR_UP;
          res_d.done_res   = stk_stat.last;
          chk_vld_d        = 1'b0;
          state_d          = S_EMIT;
        end else begin
          // Probe the next direction; its visited bit returns next cycle.
          vis_req.rd_en = cand_inb;
          chk_vld_d     = 1'b1;
          chk_inb_d     = cand_inb;
          chk_last_d    = (iss_q == 2'd3);
          chk_dir_d     = cur_dir;
          chk_x_d       = cand_x_ext[XW-1:0];
          chk_y_d       = cand_y_ext[YW-1:0];
          chk_addr_d    = cand_addr;
          iss_d         = iss_q + 2'd1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iss_q       <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    order_q    <= order_d;
    chk_inb_q  <= chk_inb_d;
    chk_last_q <= chk_last_d;
    chk_dir_q  <= chk_dir_d;
    chk_x_q    <= chk_x_d;
    chk_y_q    <= chk_y_d;
    chk_addr_q <= chk_addr_d;
    if (res_we) begin
      res_q <= res_d;
    end
    if (state_q == S_EMIT && out_free) begin
      out_beat_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  `GMB_ASSERT_IMPL(a_scan_has_top, clk_i, rst_ni, state_q == S_SCAN, !stk_stat.empty, "scan with empty stack")
  `GMB_ASSERT_IMPL(a_push_fresh, clk_i, rst_ni, stk_op == STK_PUSH, vis_req.wr_en && !vis_visited && !stk_stat.full, "push of visited cell")
  `GMB_ASSERT_NEXT(a_pop_last_empties, clk_i, rst_ni, stk_op == STK_POP && stk_stat.last, stk_stat.empty, "stack not empty after final pop")

endmodule

`default_nettype wire

@@ tb/grid_maze_backtracker_tb.sv @@
`timescale 1ns / 1ps

module grid_maze_backtracker_tb;
  import gmb_pkg::*;

  localparam int GRID_MAX    = 64;
  localparam int CELLS       = GRID_MAX * GRID_MAX;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 1300;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_beat_t             in_beat_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_beat_t            out_beat_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  grid_maze_backtracker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the carver state
  bit         visited_cells [CELLS];
  logic [5:0] path_x [CELLS];
  logic [5:0] path_y [CELLS];
  int         path_depth = 0;
  logic [6:0] grid_cols_w = 7'd64;
  logic [6:0] grid_rows_w = 7'd64;

  in_beat_t   beats_to_send [$];
  out_beat_t  maze_events [$];
  int         mismatches  = 0;
  int unsigned cycle_count = 0;
  bit         calm = 1'b0;

  function automatic int clamp_size(logic [6:0] v);
    if (v == 7'd0) return 1;
    if (int'(v) > GRID_MAX) return GRID_MAX;
    return int'(v);
  endfunction

  function automatic out_beat_t walk_maze(in_beat_t b);
    out_beat_t r;
    dir_e order [4];
    dir_e tmp;
    int picks [3];
    int cols, rows, x, y, nx, ny, dx, dy, j;
    bit found;
    r = '0;
    if (func_e'(b.func) == FN_START) begin
      foreach (visited_cells[k]) visited_cells[k] = 1'b0;
      visited_cells[0] = 1'b1;
      path_x[0] = '0;
      path_y[0] = '0;
      path_depth = 1;
      r.event_kind = EV_START;
    end else if (path_depth == 0) begin
      r.event_kind = EV_IDLE;
      r.done_res = 1'b1;
    end else begin
      cols = clamp_size(grid_cols_w);
      rows = clamp_size(grid_rows_w);
      order = '{DIR_UP, DIR_RIGHT, DIR_DOWN, DIR_LEFT};
      picks[0] = b.pick_first;
      picks[1] = b.pick_second;
      picks[2] = b.pick_third;
      // a pick at or below its own position leaves the order alone
      for (int i = 0; i < 3; i++) begin
        j = picks[i];
        if (j > i) begin
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
      end
      x = path_x[path_depth-1];
      y = path_y[path_depth-1];
      found = 1'b0;
      for (int i = 0; i < 4 && !found; i++) begin
        case (order[i])
          DIR_UP:    begin dx = 0;  dy = -1; end
          DIR_RIGHT: begin dx = 1;  dy = 0;  end
          DIR_DOWN:  begin dx = 0;  dy = 1;  end
          default:   begin dx = -1; dy = 0;  end
        endcase
        nx = x + dx;
        ny = y + dy;
        if (nx >= 0 && nx < cols && ny >= 0 && ny < rows &&
            !visited_cells[ny*GRID_MAX + nx] && path_depth < CELLS) begin
          found = 1'b1;
          visited_cells[ny*GRID_MAX + nx] = 1'b1;
          path_x[path_depth] = 6'(nx);
          path_y[path_depth] = 6'(ny);
          path_depth++;
          r.carve_dir = order[i];
        end
      end
      r.cell_x = 6'(x);
      r.cell_y = 6'(y);
      if (found) begin
        r.event_kind = EV_CARVE;
      end else begin
        r.event_kind = EV_BACK;
        path_depth--;
        r.done_res = (path_depth == 0);
      end
    end
    return r;
  endfunction

  // Driver: predict on every accepted beat, then load the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) maze_events.push_back(walk_maze(in_beat_i));
      if (!in_valid_i || !in_stall_o) begin
        if (beats_to_send.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
          in_beat_i  <= beats_to_send.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor
  always @(posedge clk_i) begin : monitor
    out_beat_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (maze_events.size() == 0) begin
          $error("unexpected result beat %h", out_beat_o);
          mismatches++;
        end else begin
          want = maze_events.pop_front();
          if ($isunknown(out_beat_o)) begin
            $error("result beat: expected %h, got %h", want, out_beat_o);
            mismatches++;
          end
          check_field("event_kind", want.event_kind, out_beat_o.event_kind);
          check_field("cell_x", want.cell_x, out_beat_o.cell_x);
          check_field("cell_y", want.cell_y, out_beat_o.cell_y);
          check_field("carve_dir", want.carve_dir, out_beat_o.carve_dir);
          check_field("done_res", want.done_res, out_beat_o.done_res);
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < 32);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_beat(func_e f, int p0, int p1, int p2);
    in_beat_t b;
    b.func        = f;
    b.pick_first  = 2'(p0);
    b.pick_second = 2'(p1);
    b.pick_third  = 2'(p2);
    beats_to_send.push_back(b);
  endtask

  task automatic push_steps(int n);
    for (int i = 0; i < n; i++)
      push_beat(FN_STEP, $urandom_range(3), $urandom_range(3), $urandom_range(3));
  endtask

  // Hold until every beat is out and every result is back, then let the block settle
  task automatic drain();
    while (beats_to_send.size() > 0 || in_valid_i || maze_events.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [6:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_COLS) grid_cols_w = val;
    else grid_rows_w = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [6:0] random_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 6) return 7'd0;
    if (roll < 12) return 7'($urandom_range(65, 127));
    if (roll < 16) return 7'd64;
    return 7'($urandom_range(1, 6));
  endfunction

  initial begin : stimulus
    int sent, full, nsteps, half, mazes;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full-size grid: step while idle, start, several shuffles, restart mid-maze
    push_beat(FN_STEP, 0, 0, 0);
    push_beat(FN_START, 0, 0, 0);
    push_beat(FN_STEP, 3, 3, 3);
    push_beat(FN_STEP, 0, 0, 0);
    push_beat(FN_STEP, 1, 2, 3);
    push_beat(FN_STEP, 2, 1, 2);
    push_beat(FN_STEP, 3, 0, 1);
    push_beat(FN_START, 3, 3, 3);
    push_beat(FN_STEP, 0, 1, 2);
    drain();

    // zero columns act as one, oversized rows act as the maximum
    write_reg(CFG_COLS, 7'd0);
    write_reg(CFG_ROWS, 7'd127);
    push_beat(FN_START, 1, 1, 2);
    push_beat(FN_STEP, 3, 3, 3);
    push_beat(FN_STEP, 0, 3, 2);
    push_beat(FN_STEP, 2, 2, 3);
    drain();

    // shrink under a live stack: walk back out, then idle
    write_reg(CFG_ROWS, 7'd1);
    push_steps(5);
    drain();

    write_reg(CFG_COLS, 7'd127);
    write_reg(CFG_ROWS, 7'd0);
    push_beat(FN_START, 0, 0, 0);
    push_beat(FN_STEP, 1, 1, 2);
    push_beat(FN_STEP, 0, 0, 0);
    drain();

    sent = 0;
    while (sent < ITEM_TARGET) begin
      calm = (sent >= 500 && sent < 750);
      write_reg(CFG_COLS, random_size());
      write_reg(CFG_ROWS, random_size());
      mazes = $urandom_range(1, 3);
      for (int m = 0; m < mazes; m++) begin
        if ($urandom_range(99) < 5) push_steps(1);
        push_beat(FN_START, $urandom_range(3), $urandom_range(3), $urandom_range(3));
        full = 2 * clamp_size(grid_cols_w) * clamp_size(grid_rows_w) - 1;
        if (full > 150) nsteps = $urandom_range(20, 90);
        else if ($urandom_range(99) < 10) nsteps = $urandom_range(0, full);
        else nsteps = full + $urandom_range(0, 2);
        sent += 1 + ((nsteps < full) ? nsteps : full);
        half = nsteps / 2;
        push_steps(half);
        if (nsteps > 4 && $urandom_range(99) < 12) begin
          drain();
          write_reg($urandom_range(1) ? CFG_COLS : CFG_ROWS, 7'($urandom_range(1, 4)));
        end else if ($urandom_range(99) < 8) begin
          drain();
        end
        push_steps(nsteps - half);
      end
      drain();
    end
    calm = 1'b0;

    while (beats_to_send.size() > 0 || in_valid_i || maze_events.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
